// ===== design/lmw_pkg.sv =====
// ----------------------------------------------------------------------------
// lmw_pkg
// Shared types and constants for the motion watchdog core.
// ----------------------------------------------------------------------------
package lmw_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CFG_W       = 16;
   localparam int CNT_W       = 16;
   localparam int CMP_W       = 17;   // threshold compare width
   localparam int RSP_TICKS_W = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_LIMIT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_INTERVAL  = 2'd2;

   localparam logic [CFG_W-1:0] MOTION_THRESHOLD_RST = 16'd500;
   localparam logic [CFG_W-1:0] LOST_LIMIT_RST       = 16'd6;
   localparam logic [CFG_W-1:0] REPORT_INTERVAL_RST  = 16'd1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] motion_threshold;
      logic [CFG_W-1:0] lost_limit;
      logic [CFG_W-1:0] report_interval;
   } cfg_type;

   typedef struct packed {
      logic moving;
      logic is_lost;
      logic send_report;
      logic make_discoverable;
      logic recovered;
   } flags_type;

endpackage

// ===== design/lmw_motion.sv =====
// ----------------------------------------------------------------------------
// lmw_motion
// Per-axis absolute difference against the previous sample, any axis over
// the threshold flags motion.
// ----------------------------------------------------------------------------
module lmw_motion #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic signed [SAMPLE_WIDTH-1:0] cur_x,
   input  logic signed [SAMPLE_WIDTH-1:0] cur_y,
   input  logic signed [SAMPLE_WIDTH-1:0] cur_z,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_x,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_y,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_z,
   input  logic [lmw_pkg::CFG_W-1:0]      threshold,
   output logic                           moving
);

   localparam int DiffW = SAMPLE_WIDTH + 1;
   localparam int CmpW  = lmw_pkg::CMP_W;

   function automatic logic over_thr(input logic [SAMPLE_WIDTH-1:0] a,
                                     input logic [SAMPLE_WIDTH-1:0] b,
                                     input logic [lmw_pkg::CFG_W-1:0] thr);
      logic [DiffW-1:0] d;
      logic [DiffW-1:0] mag;
      d   = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
      mag = d[DiffW-1] ? (~d + 1'b1) : d;
      return CmpW'(mag) > CmpW'(thr);
   endfunction

   assign moving = over_thr(cur_x, prev_x, threshold) |
                   over_thr(cur_y, prev_y, threshold) |
                   over_thr(cur_z, prev_z, threshold);

endmodule

// ===== design/lmw_tracker.sv =====
// ----------------------------------------------------------------------------
// lmw_tracker
// Watchdog state: previous sample, idle/report/lost counters and mode.
// Computes the next state and the result flags for the item in flight.
// ----------------------------------------------------------------------------
module lmw_tracker #(
   parameter int SAMPLE_WIDTH     = 16,
   parameter int LOST_COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]  cur_x,
   input  logic signed [SAMPLE_WIDTH-1:0]  cur_y,
   input  logic signed [SAMPLE_WIDTH-1:0]  cur_z,
   input  lmw_pkg::cfg_type                cfg,
   output lmw_pkg::flags_type              flags,
   output logic [LOST_COUNT_WIDTH-1:0]     lost_count
);

   logic signed [SAMPLE_WIDTH-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic signed [SAMPLE_WIDTH-1:0] prev_x_in, prev_y_in, prev_z_in;
   logic [lmw_pkg::CNT_W-1:0]      idle_ff, idle_in, idle_inc;
   logic [lmw_pkg::CNT_W-1:0]      report_ff, report_in, report_inc;
   logic [LOST_COUNT_WIDTH-1:0]    lost_ff, lost_in;
   logic                           mode_ff, mode_in;
   logic                           pend_ff, pend_in;
   logic                           moving;

   lmw_motion #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_motion (
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .cur_z     (cur_z),
      .prev_x    (prev_x_ff),
      .prev_y    (prev_y_ff),
      .prev_z    (prev_z_ff),
      .threshold (cfg.motion_threshold),
      .moving    (moving)
   );

   assign idle_inc   = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign report_inc = (report_ff == '1) ? report_ff : report_ff + 1'b1;

   always_comb begin
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      prev_z_in = prev_z_ff;
      idle_in   = idle_ff;
      report_in = report_ff;
      lost_in   = lost_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      flags     = '0;
      if (cmd == lmw_pkg::CMD_SAMPLE) begin
         prev_x_in    = cur_x;
         prev_y_in    = cur_y;
         prev_z_in    = cur_z;
         flags.moving = moving;
         if (moving) begin
            idle_in = '0;
            if (mode_ff) begin
               mode_in         = 1'b0;
               pend_in         = 1'b0;
               flags.recovered = 1'b1;
            end
         end
         // first lost report goes out on the next sample still in lost mode
         if (mode_in && pend_in) begin
            flags.send_report       = 1'b1;
            flags.make_discoverable = 1'b1;
            pend_in                 = 1'b0;
         end
      end else if (!mode_ff) begin
         idle_in = idle_inc;
         if (idle_inc >= cfg.lost_limit) begin
            mode_in   = 1'b1;
            pend_in   = 1'b1;
            report_in = '0;
            lost_in   = '0;
         end
      end else begin
         lost_in   = (lost_ff == '1) ? lost_ff : lost_ff + 1'b1;
         report_in = report_inc;
         if (report_inc >= cfg.report_interval) begin
            flags.send_report = 1'b1;
            report_in         = '0;
         end
      end
      flags.is_lost = mode_in;
   end

   assign lost_count = lost_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
         idle_ff   <= '0;
         report_ff <= '0;
         lost_ff   <= '0;
         mode_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else if (step) begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         prev_z_ff <= prev_z_in;
         idle_ff   <= idle_in;
         report_ff <= report_in;
         lost_ff   <= lost_in;
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

// ===== design/lost_device_motion_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// lost_device_motion_watchdog_core
// Accelerometer inactivity watchdog with lost-mode reporting.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a request accepted into the
// input register moves to the result register when that one is empty or taken.
// Throughput: one word per cycle unless the receiver stalls; the state update is
// a single pass of compare and counter logic between the two registers.
// Reset (synchronous, active high) empties both registers, puts the block in
// found mode with all counters and the previous sample at zero, and loads
// the register defaults (threshold 500, lost limit 6, report interval 1).
// ----------------------------------------------------------------------------
module lost_device_motion_watchdog_core #(
   parameter int SAMPLE_WIDTH     = 16,
   parameter int LOST_COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [15:0]                  req_accel_x,
   input  logic signed [15:0]                  req_accel_y,
   input  logic signed [15:0]                  req_accel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_moving,
   output logic                                rsp_is_lost,
   output logic                                rsp_send_report,
   output logic                                rsp_make_discoverable,
   output logic                                rsp_recovered,
   output logic [lmw_pkg::RSP_TICKS_W-1:0]     rsp_lost_ticks,
   input  logic                                csr_write,
   input  logic [lmw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lmw_pkg::CSR_DATA_W-1:0]      csr_data
);

   lmw_pkg::cfg_type               cfg_ff;
   logic                           in_valid_ff;
   logic                           cmd_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, y_ff, z_ff;
   logic                           out_valid_ff;
   lmw_pkg::flags_type             flags_ff, flags_in;
   logic [LOST_COUNT_WIDTH-1:0]    ticks_ff, ticks_in;
   logic                           advance;
   logic                           step;
   logic                           req_take;

   // result register frees up when empty or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_threshold <= lmw_pkg::MOTION_THRESHOLD_RST;
         cfg_ff.lost_limit       <= lmw_pkg::LOST_LIMIT_RST;
         cfg_ff.report_interval  <= lmw_pkg::REPORT_INTERVAL_RST;
      end else if (csr_write) begin
         case (csr_index)
            lmw_pkg::CSR_MOTION_THRESHOLD: cfg_ff.motion_threshold <= csr_data;
            lmw_pkg::CSR_LOST_LIMIT:       cfg_ff.lost_limit       <= csr_data;
            lmw_pkg::CSR_REPORT_INTERVAL:  cfg_ff.report_interval  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_cmd;
         x_ff   <= req_accel_x[SAMPLE_WIDTH-1:0];
         y_ff   <= req_accel_y[SAMPLE_WIDTH-1:0];
         z_ff   <= req_accel_z[SAMPLE_WIDTH-1:0];
      end
   end

   lmw_tracker #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .LOST_COUNT_WIDTH (LOST_COUNT_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (cmd_ff),
      .cur_x      (x_ff),
      .cur_y      (y_ff),
      .cur_z      (z_ff),
      .cfg        (cfg_ff),
      .flags      (flags_in),
      .lost_count (ticks_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         flags_ff <= flags_in;
         ticks_ff <= ticks_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_moving            = flags_ff.moving;
   assign rsp_is_lost           = flags_ff.is_lost;
   assign rsp_send_report       = flags_ff.send_report;
   assign rsp_make_discoverable = flags_ff.make_discoverable;
   assign rsp_recovered         = flags_ff.recovered;
   assign rsp_lost_ticks        = lmw_pkg::RSP_TICKS_W'(ticks_ff);

endmodule

// ===== tb/tb_lost_device_motion_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// tb_lost_device_motion_watchdog_core
// Self-checking bench for the motion watchdog core. A predictor tracks the
// previous sample, the idle and lost counters and the mode for every
// accepted word. Each result word is checked field by field against the
// oldest prediction. Directed cases cover the register extremes and the
// mode transitions. Random traffic then runs under several idle and stall
// mixes, and a long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_lost_device_motion_watchdog_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lmw_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int RESULT_LATENCY = 2;
   localparam int QUIET_LIMIT    = 5000;

   typedef struct packed {
      lmw_pkg::flags_type              flags;
      logic [lmw_pkg::RSP_TICKS_W-1:0] lost_ticks;
   } watchdog_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   logic                               req_cmd     = lmw_pkg::CMD_SAMPLE;
   logic signed [15:0]                 req_accel_x = '0;
   logic signed [15:0]                 req_accel_y = '0;
   logic signed [15:0]                 req_accel_z = '0;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   logic                               rsp_moving;
   logic                               rsp_is_lost;
   logic                               rsp_send_report;
   logic                               rsp_make_discoverable;
   logic                               rsp_recovered;
   logic [lmw_pkg::RSP_TICKS_W-1:0]    rsp_lost_ticks;
   logic                               csr_write   = 1'b0;
   logic [lmw_pkg::CSR_INDEX_W-1:0]    csr_index   = lmw_pkg::CSR_MOTION_THRESHOLD;
   logic [lmw_pkg::CSR_DATA_W-1:0]     csr_data    = '0;

   lost_device_motion_watchdog_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd               (req_cmd),
      .req_accel_x           (req_accel_x),
      .req_accel_y           (req_accel_y),
      .req_accel_z           (req_accel_z),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_moving            (rsp_moving),
      .rsp_is_lost           (rsp_is_lost),
      .rsp_send_report       (rsp_send_report),
      .rsp_make_discoverable (rsp_make_discoverable),
      .rsp_recovered         (rsp_recovered),
      .rsp_lost_ticks        (rsp_lost_ticks),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // predictor state
   lmw_pkg::cfg_type                wd_cfg;
   logic signed [15:0]              wd_prev_x, wd_prev_y, wd_prev_z;
   logic [lmw_pkg::CNT_W-1:0]       wd_idle;
   logic [lmw_pkg::CNT_W-1:0]       wd_report;
   logic [lmw_pkg::RSP_TICKS_W-1:0] wd_ticks;
   logic                            wd_lost;
   logic                            wd_first_pending;

   watchdog_result_type expected_results[$];
   int error_count = 0;

   // traffic shaping
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;

   // stimulus-side copies, used to shape quiet samples
   logic signed [15:0] last_x = '0, last_y = '0, last_z = '0;
   int stim_threshold = lmw_pkg::MOTION_THRESHOLD_RST;

   function automatic int axis_delta(logic signed [15:0] a, logic signed [15:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic watchdog_result_type predict_watchdog(logic cmd,
                                                            logic signed [15:0] x,
                                                            logic signed [15:0] y,
                                                            logic signed [15:0] z);
      watchdog_result_type res;
      logic motion;
      res = '0;
      if (cmd == lmw_pkg::CMD_SAMPLE) begin
         motion = axis_delta(x, wd_prev_x) > int'(wd_cfg.motion_threshold) ||
                  axis_delta(y, wd_prev_y) > int'(wd_cfg.motion_threshold) ||
                  axis_delta(z, wd_prev_z) > int'(wd_cfg.motion_threshold);
         wd_prev_x = x;
         wd_prev_y = y;
         wd_prev_z = z;
         res.flags.moving = motion;
         if (motion) begin
            wd_idle = '0;
            if (wd_lost) begin
               wd_lost = 1'b0;
               wd_first_pending = 1'b0;
               res.flags.recovered = 1'b1;
            end
         end
         if (wd_lost && wd_first_pending) begin
            res.flags.send_report = 1'b1;
            res.flags.make_discoverable = 1'b1;
            wd_first_pending = 1'b0;
         end
      end else if (!wd_lost) begin
         if (wd_idle != '1) wd_idle++;
         if (wd_idle >= wd_cfg.lost_limit) begin
            wd_lost = 1'b1;
            wd_first_pending = 1'b1;
            wd_report = '0;
            wd_ticks = '0;
         end
      end else begin
         if (wd_ticks != '1) wd_ticks++;
         if (wd_report != '1) wd_report++;
         if (wd_report >= wd_cfg.report_interval) begin
            res.flags.send_report = 1'b1;
            wd_report = '0;
         end
      end
      res.flags.is_lost = wd_lost;
      res.lost_ticks = wd_ticks;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wd_cfg.motion_threshold = lmw_pkg::MOTION_THRESHOLD_RST;
         wd_cfg.lost_limit = lmw_pkg::LOST_LIMIT_RST;
         wd_cfg.report_interval = lmw_pkg::REPORT_INTERVAL_RST;
         wd_prev_x = '0;
         wd_prev_y = '0;
         wd_prev_z = '0;
         wd_idle = '0;
         wd_report = '0;
         wd_ticks = '0;
         wd_lost = 1'b0;
         wd_first_pending = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lmw_pkg::CSR_MOTION_THRESHOLD: wd_cfg.motion_threshold = csr_data;
               lmw_pkg::CSR_LOST_LIMIT:       wd_cfg.lost_limit = csr_data;
               lmw_pkg::CSR_REPORT_INTERVAL:  wd_cfg.report_interval = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_watchdog(req_cmd, req_accel_x,
                                                        req_accel_y, req_accel_z));
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_rsp
      watchdog_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_error("result word with nothing expected");
         end else begin
            want = expected_results.pop_front();
            check_field("moving", rsp_moving, want.flags.moving);
            check_field("is_lost", rsp_is_lost, want.flags.is_lost);
            check_field("send_report", rsp_send_report, want.flags.send_report);
            check_field("make_discoverable", rsp_make_discoverable,
                        want.flags.make_discoverable);
            check_field("recovered", rsp_recovered, want.flags.recovered);
            check_field("lost_ticks", rsp_lost_ticks, want.lost_ticks);
         end
      end
   end

   // receiver: random stall, or a forced hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // called and returns at a falling edge; valid stays high unless a gap is drawn
   task automatic send_word(input logic cmd, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      req_cmd <= cmd;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      req_valid <= 1'b1;
      if (cmd == lmw_pkg::CMD_SAMPLE) begin
         last_x = x;
         last_y = y;
         last_z = z;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (RESULT_LATENCY + 1) @(negedge clock);
   endtask

   task automatic set_reg(input logic [lmw_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [lmw_pkg::CSR_DATA_W-1:0] val);
      wait_for_results();
      csr_index <= idx;
      csr_data <= val;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == lmw_pkg::CSR_MOTION_THRESHOLD) stim_threshold = val;
   endtask

   task automatic tick();
      send_word(lmw_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // reset defaults: first sample against zero, entry into lost mode, first
   // report, recovery
   task automatic test_reset_defaults();
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd500, -16'sd500, 16'sd0);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd1001, -16'sd500, 16'sd0);
      repeat (6) tick();
      tick();
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd1001, -16'sd500, 16'sd0);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd1001, 16'sd0, 16'sd0);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd1001, 16'sd0, 16'sd501);
   endtask

   // full-scale swings need the 17-bit difference
   task automatic test_threshold_extremes();
      set_reg(lmw_pkg::CSR_MOTION_THRESHOLD, 16'hFFFE);
      send_word(lmw_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd32767, -16'sd32768, -16'sd32768);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767);
      set_reg(lmw_pkg::CSR_MOTION_THRESHOLD, 16'hFFFF);
      send_word(lmw_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
      set_reg(lmw_pkg::CSR_MOTION_THRESHOLD, 16'h0000);
      send_word(lmw_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
      send_word(lmw_pkg::CMD_SAMPLE, -16'sd32767, -16'sd32768, -16'sd32768);
   endtask

   // zero limit and interval, an unmapped register index, top values
   task automatic test_limit_extremes();
      set_reg(lmw_pkg::CSR_LOST_LIMIT, 16'h0000);
      set_reg(lmw_pkg::CSR_REPORT_INTERVAL, 16'h0000);
      repeat (3) tick();
      send_word(lmw_pkg::CMD_SAMPLE, -16'sd32767, -16'sd32768, -16'sd32768);
      set_reg(CSR_UNMAPPED, 16'hFFFF);
      tick();
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
      set_reg(lmw_pkg::CSR_LOST_LIMIT, 16'h0001);
      set_reg(lmw_pkg::CSR_REPORT_INTERVAL, 16'h0003);
      repeat (4) tick();
      set_reg(lmw_pkg::CSR_MOTION_THRESHOLD, lmw_pkg::MOTION_THRESHOLD_RST);
      set_reg(lmw_pkg::CSR_LOST_LIMIT, 16'hFFFF);
      set_reg(lmw_pkg::CSR_REPORT_INTERVAL, 16'hFFFF);
      send_word(lmw_pkg::CMD_SAMPLE, 16'sd2000, 16'sd0, 16'sd0);
      repeat (2) tick();
   endtask

   function automatic logic signed [15:0] nudge(logic signed [15:0] base, int span);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic send_random_word();
      int r, span;
      logic signed [15:0] corners[4];
      corners = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
      r = $urandom_range(99);
      span = (stim_threshold > 4000) ? 4000 : stim_threshold;
      if (r < 60)
         tick();
      else if (r < 92)
         send_word(lmw_pkg::CMD_SAMPLE, nudge(last_x, span), nudge(last_y, span),
                   nudge(last_z, span));
      else if (r < 98)
         send_word(lmw_pkg::CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
      else
         send_word(lmw_pkg::CMD_SAMPLE, corners[$urandom_range(3)],
                   corners[$urandom_range(3)], corners[$urandom_range(3)]);
   endtask

   task automatic randomize_config();
      logic [lmw_pkg::CSR_DATA_W-1:0] thr, lim, ivl;
      case ($urandom_range(9))
         0: thr = '0;
         1: thr = '1;
         2: thr = 16'($urandom);
         default: thr = 16'($urandom_range(1, 3000));
      endcase
      case ($urandom_range(9))
         0: lim = '0;
         1: lim = '1;
         default: lim = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
         0: ivl = '0;
         1: ivl = '1;
         default: ivl = 16'($urandom_range(1, 6));
      endcase
      set_reg(lmw_pkg::CSR_MOTION_THRESHOLD, thr);
      set_reg(lmw_pkg::CSR_LOST_LIMIT, lim);
      set_reg(lmw_pkg::CSR_REPORT_INTERVAL, ivl);
      if ($urandom_range(3) == 0) set_reg(CSR_UNMAPPED, 16'($urandom));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (5) begin
         randomize_config();
         repeat (70) send_random_word();
      end
      wait_for_results();
   endtask

   // receiver holds off long enough for the core to back up into the input
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_reg(lmw_pkg::CSR_LOST_LIMIT, 16'h0004);
      set_reg(lmw_pkg::CSR_REPORT_INTERVAL, 16'h0002);
      hold_off_left = 150;
      repeat (30) send_random_word();
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_threshold_extremes();
      test_limit_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(79, 0);
      test_random_traffic(0, 79);
      test_random_traffic(8, 8);
      test_backpressure();
      wait_for_results();
      if (expected_results.size() != 0) report_error("expected words left over");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lmw_pkg.sv
design/lmw_motion.sv
design/lmw_tracker.sv
design/lost_device_motion_watchdog_core.sv
tb/tb_lost_device_motion_watchdog_core.sv
